// ===== hw/rtl/bltw_pkg.sv =====
// ----------------------------------------------------------------------------
// bltw_pkg
// Shared types, constants and the table lookup of the two-pass 3x3 filter.
// ----------------------------------------------------------------------------
package bltw_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned FillW     = $clog2(MaxWidth + 1);
  localparam int unsigned NumWords  = 8;
  localparam int unsigned WordW     = 64;
  localparam int unsigned CfgIdxW   = $clog2(NumWords);
  localparam int unsigned OnW       = 21;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned GapW      = 3;

  localparam logic [OnW-1:0]  OnMax  = {OnW{1'b1}};
  localparam logic [GapW-1:0] GapMax = 3'd7;
  localparam logic [GapW-1:0] GapWin = 3'd4;

  typedef logic [ColW-1:0] col_t;
  typedef logic [NumWords-1:0][WordW-1:0] lut_tbl_t;

  // One classified input pixel, front to back.
  typedef struct packed {
    logic px;
    col_t col;
    logic r_ge1;
    logic r_ge2;
    logic end_row;
    logic fe;
    logic emit;
  } item_t;

  // Bit n of word k is entry 64*k+n.
  function automatic logic lut(input lut_tbl_t tbl, input logic [8:0] idx);
    return tbl[idx[8:6]][idx[5:0]];
  endfunction

endpackage

// ===== hw/rtl/binary_lut_window_filter_twice_unit.sv =====
// Pipeline: the input pixel that completes a 5x5 window is queued in the FIFO,
// then passes the read stage, the lookup stage and the output register.
// Throughput: one pixel per cycle unless the output stalls; each pixel does
// one read and one write of the column memory, pipelined with same-column bypass.
// Reset: raster counters, window, on count and table words clear at once;
// the column memory is not swept, a fill count marks written columns.
// ----------------------------------------------------------------------------
// binary_lut_window_filter_twice_unit
// Two-pass binary 3x3 lookup filter over a streamed raster.
// ----------------------------------------------------------------------------
module binary_lut_window_filter_twice_unit import bltw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               pixel_in_i,
  input  logic               row_end_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               pixel_out_o,
  output logic               out_row_end_o,
  output logic               out_frame_end_o,
  output logic [OnW-1:0]     on_total_o
);

  lut_tbl_t tbl_q;
  item_t    push_item, head;
  logic     push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_q <= '0;
    end else if (cfg_we_i) begin
      tbl_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  bltw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_in_i  (pixel_in_i),
    .row_end_i   (row_end_i),
    .frame_end_i (frame_end_i),
    .fifo_full_i (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  bltw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  bltw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tbl_i           (tbl_q),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_out_o     (pixel_out_o),
    .out_row_end_o   (out_row_end_o),
    .out_frame_end_o (out_frame_end_o),
    .on_total_o      (on_total_o)
  );

endmodule

// ===== hw/rtl/bltw_front.sv =====
// ----------------------------------------------------------------------------
// bltw_front
// Tracks raster position and classifies each accepted pixel for the back end.
// ----------------------------------------------------------------------------
module bltw_front import bltw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  pixel_in_i,
  input  logic  row_end_i,
  input  logic  frame_end_i,
  input  logic  fifo_full_i,
  output logic  push_o,
  output item_t item_o
);

  localparam col_t ColLast = col_t'(MaxWidth - 1);
  localparam col_t ColTwo  = col_t'(2);

  col_t       col_q, col_d;
  logic [1:0] rcls_q, rcls_d;  // rows seen this frame, saturating at two
  logic       end_row;

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i & ~fifo_full_i;
  assign end_row    = row_end_i | frame_end_i | (col_q == ColLast);

  always_comb begin
    item_o.px      = pixel_in_i;
    item_o.col     = col_q;
    item_o.r_ge1   = (rcls_q != 2'd0);
    item_o.r_ge2   = rcls_q[1];
    item_o.end_row = end_row;
    item_o.fe      = frame_end_i;
    item_o.emit    = rcls_q[1] & (col_q >= ColTwo);
  end

  always_comb begin
    col_d  = col_q;
    rcls_d = rcls_q;
    if (push_o) begin
      if (frame_end_i) begin
        col_d  = '0;
        rcls_d = 2'd0;
      end else if (end_row) begin
        col_d  = '0;
        rcls_d = rcls_q[1] ? rcls_q : rcls_q + 2'd1;
      end else begin
        col_d  = col_q + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rcls_q <= 2'd0;
    end else begin
      col_q  <= col_d;
      rcls_q <= rcls_d;
    end
  end

endmodule

// ===== hw/rtl/bltw_fifo.sv =====
// ----------------------------------------------------------------------------
// bltw_fifo
// Short queue of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
module bltw_fifo import bltw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t head_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  item_t           buf_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = buf_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bltw_back.sv =====
// ----------------------------------------------------------------------------
// bltw_back
// Column memory, both table passes, on-pixel count and the output register.
// ----------------------------------------------------------------------------
module bltw_back import bltw_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lut_tbl_t       tbl_i,
  input  logic           empty_i,
  input  item_t          head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           pixel_out_o,
  output logic           out_row_end_o,
  output logic           out_frame_end_o,
  output logic [OnW-1:0] on_total_o
);

  // Per-column history: rows since last on pixel, two intermediate rows,
  // two input rows (bit 0 is the newer row).
  typedef struct packed {
    logic [GapW-1:0] gap;
    logic [1:0]      mid;
    logic [1:0]      inp;
  } colw_t;

  function automatic logic [8:0] shift_in(input logic [8:0] w, input logic top,
                                          input logic mid, input logic bot);
    return {w[7:6], top, w[4:3], mid, w[1:0], bot};
  endfunction

  colw_t col_mem [MaxWidth];

  logic adv;

  // read stage
  logic       s1_vld_q;
  item_t      s1_q;
  colw_t      rd_q, byp_q;
  logic       byp_hit_q, gap_ok_q;
  logic [FillW-1:0] fill_q;   // columns 0..fill-1 written since reset

  // window state
  logic [17:0] win_q;
  logic [4:0]  act_q;

  // lookup stage
  logic        s2_vld_q, s2_act_q, s2_emit_q, s2_end_q, s2_fe_q;
  logic [8:0]  s2_mid_q;
  logic [OnW-1:0] cnt_q;

  // output register
  logic           o_vld_q, o_px_q, o_end_q, o_fe_q;
  logic [OnW-1:0] o_total_q;

  assign adv   = ~o_vld_q | ~out_stall_i;
  assign pop_o = adv & ~empty_i;

  // ---- first pass -----------------------------------------------------------
  colw_t           cw, wdata;
  logic            up1, up2, colzero, mv, wr_en, gap_ok;
  logic [GapW-1:0] prev, gap;
  logic [4:0]      act_n;
  logic [8:0]      wl, wh, in_win, mid_win;

  always_comb begin
    cw      = byp_hit_q ? byp_q : rd_q;
    gap_ok  = byp_hit_q | gap_ok_q;
    up1     = s1_q.r_ge1 & cw.inp[0];
    up2     = s1_q.r_ge2 & cw.inp[1];
    prev    = s1_q.r_ge1 ? (gap_ok ? cw.gap : '0) : GapMax;
    gap     = s1_q.px ? '0 : ((prev == GapMax) ? GapMax : prev + GapW'(1));
    colzero = (s1_q.col == '0);
    act_n   = {(colzero ? 4'd0 : act_q[3:0]), (gap <= GapWin)};
    wl      = colzero ? 9'd0 : win_q[8:0];
    wh      = colzero ? 9'd0 : win_q[17:9];
    in_win  = shift_in(wl, up2, up1, s1_q.px);
    mv      = lut(tbl_i, in_win);
    mid_win = shift_in(wh, cw.mid[1], cw.mid[0], mv);
    wdata.gap = gap;
    wdata.mid = {cw.mid[0], mv};
    wdata.inp = {cw.inp[0], s1_q.px};
    wr_en   = adv & s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      col_mem[s1_q.col] <= wdata;
    end
    if (pop_o) begin
      rd_q      <= col_mem[head_i.col];
      byp_q     <= wdata;
      // a write to the same column on this edge is not yet in the array
      byp_hit_q <= wr_en & (s1_q.col == head_i.col);
      gap_ok_q  <= (FillW'(head_i.col) < fill_q);
      s1_q      <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      fill_q   <= '0;
      win_q    <= '0;
      act_q    <= '0;
    end else begin
      if (adv) s1_vld_q <= ~empty_i;
      if (wr_en) begin
        win_q <= {mid_win, in_win};
        act_q <= act_n;
        if (FillW'(s1_q.col) >= fill_q) fill_q <= FillW'(s1_q.col) + FillW'(1);
      end
    end
  end

  // ---- second pass ----------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      s2_mid_q  <= mid_win;
      s2_act_q  <= (act_n != 5'd0);
      s2_emit_q <= s1_q.emit;
      s2_end_q  <= s1_q.end_row;
      s2_fe_q   <= s1_q.fe;
    end
  end

  logic           po;
  logic [OnW-1:0] cnt_n;

  always_comb begin
    po    = s2_act_q & lut(tbl_i, s2_mid_q);
    cnt_n = (s2_emit_q && po && (cnt_q != OnMax)) ? cnt_q + OnW'(1) : cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q && s2_emit_q) begin
      o_px_q    <= po;
      o_end_q   <= s2_end_q;
      o_fe_q    <= s2_fe_q;
      o_total_q <= cnt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
      cnt_q    <= '0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
      o_vld_q  <= s2_vld_q & s2_emit_q;
      if (s2_vld_q) begin
        cnt_q <= s2_fe_q ? '0 : cnt_n;
      end
    end
  end

  assign out_valid_o     = o_vld_q;
  assign pixel_out_o     = o_px_q;
  assign out_row_end_o   = o_end_q;
  assign out_frame_end_o = o_fe_q;
  assign on_total_o      = o_total_q;

endmodule
